[design/isr_pkg.sv]
package isr_pkg;

    localparam int COORD_W = 16;

    typedef logic [COORD_W-1:0] t_coord;

    // One input request: a closed interval, the last one closing the set
    typedef struct packed {
        t_coord interval_start;
        t_coord interval_end;
        logic   last_in_set;
    } t_in_item;

    // One merged union interval
    typedef struct packed {
        t_coord merged_start;
        t_coord merged_end;
        logic   last_of_run;
        logic   overflowed;
    } t_out_item;

    // One stored interval as held in the interval RAM
    typedef struct packed {
        t_coord interval_start;
        t_coord interval_end;
    } t_entry;

    localparam int ENTRY_W = $bits(t_entry);

endpackage

[design/isr_stream_if.sv]
interface isr_stream_if #(
    parameter type t_payload = logic
) ();

    logic     valid;
    logic     ready;
    t_payload payload;

    modport source (output valid, output payload, input ready);
    modport sink   (input valid, input payload, output ready);

endinterface

[design/isr_ram.sv]
module isr_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 32
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    // one write port, one registered read port
    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/interval_sort_merge.sv]
// Channel   Dir  Payload                                        Handshake
// i_req     in   interval_start, interval_end, last_in_set      valid/ready
// o_rsp     out  merged_start, merged_end, last_of_run, overflowed  valid/ready
//
// Each request is insertion-sorted into the interval RAM as it arrives: stored into an
// empty store, else after each stored entry with a larger start moves up one place.
// A request at a full store is dropped. After the last request of a set, the merge walk
// reads the RAM once and can stall on o_rsp.ready.
// Reset is synchronous, active low, and clears the control state, not the RAM.
module interval_sort_merge #(
    parameter int MAX_INTERVALS = 32
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    isr_stream_if.sink    i_req,
    isr_stream_if.source  o_rsp
);

    import isr_pkg::*;

    localparam int AW = $clog2(MAX_INTERVALS);
    localparam int CW = $clog2(MAX_INTERVALS + 1);

    typedef enum logic [2:0] {
        S_IDLE,
        S_SHIFT,
        S_PUT,
        S_MRD,
        S_MFIRST,
        S_MWALK
    } t_state;

    t_state          r_state;
    logic [CW-1:0]   r_count;
    logic            r_ovf;
    logic            r_last;
    logic [AW-1:0]   r_j;
    t_entry          r_key;
    logic [CW-1:0]   r_i;
    t_coord          r_lo;
    t_coord          r_hi;
    t_out_item       r_out;
    logic            r_out_valid;

    logic            ram_we;
    logic [AW-1:0]   ram_waddr;
    t_entry          ram_wdata;
    logic [AW-1:0]   ram_raddr;
    logic [ENTRY_W-1:0] ram_rdata;
    t_entry          rd;

    logic            in_acc;
    logic            emit_ok;
    logic            walk_done;
    logic            extend;
    logic            walk_adv;
    logic            shift_more;

    assign rd         = t_entry'(ram_rdata);
    assign in_acc     = i_req.valid && i_req.ready;
    assign emit_ok    = !r_out_valid || o_rsp.ready;
    assign walk_done  = (r_i == r_count);
    assign extend     = (rd.interval_start <= r_hi);
    assign walk_adv   = !walk_done && (extend || emit_ok);
    assign shift_more = (rd.interval_start > r_key.interval_start);

    assign i_req.ready   = (r_state == S_IDLE);
    assign o_rsp.valid   = r_out_valid;
    assign o_rsp.payload = r_out;

    isr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (MAX_INTERVALS)
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    // RAM port control: read one ahead while shifting, one ahead while walking
    always_comb begin
        ram_we    = 1'b0;
        ram_waddr = r_j;
        ram_wdata = r_key;
        ram_raddr = r_j - AW'(2);
        unique case (r_state)
            S_IDLE: begin
                ram_raddr = AW'(r_count - CW'(1));
                if (in_acc && (r_count == '0)) begin
                    ram_we    = 1'b1;
                    ram_waddr = '0;
                    ram_wdata = '{interval_start: i_req.payload.interval_start,
                                  interval_end:   i_req.payload.interval_end};
                end
            end
            S_SHIFT: begin
                ram_we = 1'b1;
                if (shift_more) begin
                    ram_wdata = rd;
                end
            end
            S_PUT: begin
                ram_we    = 1'b1;
                ram_waddr = '0;
            end
            S_MRD: begin
                ram_raddr = '0;
            end
            S_MFIRST: begin
                ram_raddr = AW'(1);
            end
            S_MWALK: begin
                ram_raddr = walk_adv ? AW'(r_i + CW'(1)) : AW'(r_i);
            end
            default: begin
                ram_raddr = '0;
            end
        endcase
    end

    // sequencer: insert on load, merge walk after the last request
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_count     <= '0;
            r_ovf       <= 1'b0;
            r_last      <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            if (o_rsp.ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (in_acc) begin
                        r_key  <= '{interval_start: i_req.payload.interval_start,
                                    interval_end:   i_req.payload.interval_end};
                        r_last <= i_req.payload.last_in_set;
                        r_j    <= AW'(r_count);
                        if (r_count == CW'(MAX_INTERVALS)) begin
                            // store full: drop and flag
                            r_ovf <= 1'b1;
                            if (i_req.payload.last_in_set) begin
                                r_state <= S_MRD;
                            end
                        end else begin
                            r_count <= r_count + CW'(1);
                            if (r_count != '0) begin
                                r_state <= S_SHIFT;
                            end else if (i_req.payload.last_in_set) begin
                                r_state <= S_MRD;
                            end
                        end
                    end
                end
                S_SHIFT: begin
                    if (shift_more) begin
                        r_j <= r_j - AW'(1);
                        if (r_j == AW'(1)) begin
                            r_state <= S_PUT;
                        end
                    end else begin
                        r_state <= r_last ? S_MRD : S_IDLE;
                    end
                end
                S_PUT: begin
                    r_state <= r_last ? S_MRD : S_IDLE;
                end
                S_MRD: begin
                    r_state <= S_MFIRST;
                end
                S_MFIRST: begin
                    r_lo    <= rd.interval_start;
                    r_hi    <= rd.interval_end;
                    r_i     <= CW'(1);
                    r_state <= S_MWALK;
                end
                S_MWALK: begin
                    if (walk_done) begin
                        // close the final union and end the set
                        if (emit_ok) begin
                            r_out_valid <= 1'b1;
                            r_out       <= '{merged_start: r_lo, merged_end: r_hi,
                                             last_of_run: 1'b1, overflowed: r_ovf};
                            r_count     <= '0;
                            r_ovf       <= 1'b0;
                            r_state     <= S_IDLE;
                        end
                    end else if (extend) begin
                        if (rd.interval_end > r_hi) begin
                            r_hi <= rd.interval_end;
                        end
                        r_i <= r_i + CW'(1);
                    end else if (emit_ok) begin
                        r_out_valid <= 1'b1;
                        r_out       <= '{merged_start: r_lo, merged_end: r_hi,
                                         last_of_run: 1'b0, overflowed: r_ovf};
                        r_lo        <= rd.interval_start;
                        r_hi        <= rd.interval_end;
                        r_i         <= r_i + CW'(1);
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

endmodule

[design/isr_checker.sv]
module isr_checker (
    input logic               i_clk,
    input logic               i_rst_n,
    input logic               i_req_valid,
    input logic               i_req_ready,
    input logic               i_req_last,
    input logic               i_rsp_valid,
    input logic               i_rsp_ready,
    input isr_pkg::t_out_item i_rsp_payload
);

    import isr_pkg::*;

    logic [1:0] r_open;
    logic       set_close;
    logic       set_done;

    assign set_close = i_req_valid && i_req_ready && i_req_last;
    assign set_done  = i_rsp_valid && i_rsp_ready && i_rsp_payload.last_of_run;

    // closed sets whose final result is not yet taken
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_open <= 2'd0;
        end else if (set_close && !set_done) begin
            r_open <= r_open + 2'd1;
        end else if (!set_close && set_done) begin
            r_open <= r_open - 2'd1;
        end
    end

    a_no_load_behind_two_sets: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_req_valid && i_req_ready) |-> (r_open != 2'd2))
        else $error("request accepted while two sets were still pending");

    a_rsp_only_for_closed_set: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_rsp_valid |-> (r_open != 2'd0))
        else $error("result shown with no closed set pending");

    a_rsp_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_rsp_valid && !i_rsp_ready) |=> (i_rsp_valid && $stable(i_rsp_payload)))
        else $error("stalled result changed");

    a_ovf_steady: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        ((i_rsp_valid && i_rsp_ready && !i_rsp_payload.last_of_run) ##1 i_rsp_valid)
        |-> (i_rsp_payload.overflowed == $past(i_rsp_payload.overflowed)))
        else $error("overflow flag changed within one set");

endmodule

bind interval_sort_merge isr_checker u_isr_checker (
    .i_clk         (i_clk),
    .i_rst_n       (i_rst_n),
    .i_req_valid   (i_req.valid),
    .i_req_ready   (i_req.ready),
    .i_req_last    (i_req.payload.last_in_set),
    .i_rsp_valid   (o_rsp.valid),
    .i_rsp_ready   (o_rsp.ready),
    .i_rsp_payload (o_rsp.payload)
);
